### rtl/core/checkpoint_deadline_watchdog_assert.svh
// Assertion macros for the checker module of the watchdog.
// Each macro expects signals named clk and rst_n in the enclosing scope.
`ifndef CHECKPOINT_DEADLINE_WATCHDOG_ASSERT_SVH
`define CHECKPOINT_DEADLINE_WATCHDOG_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CDW_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define CDW_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/cdw_pkg.sv
package cdw_pkg;

  // Default sizes of the watchdog.
  localparam int CHANNELS_DEF    = 8;
  localparam int CHECKPOINTS_DEF = 16;
  localparam int COUNT_WIDTH_DEF = 16;

  // Fixed field widths of the words on the channels.
  localparam int MODE_W = 2;
  localparam int CHAN_W = 3;
  localparam int CP_W   = 4;
  localparam int DL_W   = 16;
  localparam int MASK_W = 8;

  // Operation codes carried in the mode field.
  localparam logic [MODE_W-1:0] MODE_TICK        = 2'd0;
  localparam logic [MODE_W-1:0] MODE_REPORT      = 2'd1;
  localparam logic [MODE_W-1:0] MODE_WRITE_DL    = 2'd2;
  localparam logic [MODE_W-1:0] MODE_WRITE_FINAL = 2'd3;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [CHAN_W-1:0] channel;
    logic [CP_W-1:0]   checkpoint;
    logic [DL_W-1:0]   deadline_value;
  } in_word_t;

  typedef struct packed {
    logic [MASK_W-1:0] expired_mask;
    logic [MASK_W-1:0] armed_mask;
  } out_word_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_TICK,
    ST_LOAD,
    ST_FINISH
  } state_t;

endpackage

### rtl/core/cdw_ram.sv
module cdw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/core/checkpoint_deadline_watchdog.sv
// Multi-channel checkpoint deadline watchdog.
// Input words (in_valid/in_ready/in_data) carry a mode: a tick, a checkpoint
// report, a deadline table write or a final-checkpoint write. Every accepted
// word produces exactly one result word (out_valid/out_ready/out_data) with
// the channels that expired on a tick and the armed channels after the word.
// One word is handled at a time and in_ready is low while it is in work.
// A tick sweeps the channel counters through one shared decrementer, one
// channel per cycle in ST_TICK, then registers its result in ST_FINISH. A
// report that loads a deadline reads the deadline memory (registered read)
// into the counter in ST_LOAD before ST_FINISH; every other word goes
// straight to ST_FINISH, where the result is registered.
// The next word is accepted in the cycle after the result is registered.
// The result sits in an output register; while the receiver stalls the block
// keeps taking and working on the next word and holds at its end until the
// output register is free.
// After reset the deadline memory is cleared one entry per cycle, all
// CHANNELS * CHECKPOINTS entries, while in_ready stays low. Counters,
// armed bits and final checkpoints are cleared by reset at once.
module checkpoint_deadline_watchdog #(
  parameter int CHANNELS    = cdw_pkg::CHANNELS_DEF,
  parameter int CHECKPOINTS = cdw_pkg::CHECKPOINTS_DEF,
  parameter int COUNT_WIDTH = cdw_pkg::COUNT_WIDTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  cdw_pkg::in_word_t in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output cdw_pkg::out_word_t out_data
);

  import cdw_pkg::*;

  localparam int DEPTH = CHANNELS * CHECKPOINTS;
  localparam int AW    = $clog2(DEPTH);
  localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  state_t                 state_r, state_nxt;
  logic [IDX_W-1:0]       idx_r, idx_nxt;
  logic [AW-1:0]          clr_r, clr_nxt;
  logic [IDX_W-1:0]       ch_r, ch_nxt;
  logic [CHANNELS-1:0]    expired_r, expired_nxt;
  logic [CHANNELS-1:0]    armed_r, armed_nxt;
  logic [COUNT_WIDTH-1:0] countdown_r [CHANNELS];
  logic [COUNT_WIDTH-1:0] countdown_nxt [CHANNELS];
  logic [CP_W-1:0]        final_r [CHANNELS];
  logic [CP_W-1:0]        final_nxt [CHANNELS];
  logic                   out_valid_r, out_valid_nxt;
  out_word_t              out_data_r, out_data_nxt;

  logic                   ram_we;
  logic [AW-1:0]          ram_waddr;
  logic [COUNT_WIDTH-1:0] ram_wdata;
  logic [AW-1:0]          acc_addr;
  logic [COUNT_WIDTH-1:0] ram_rdata;

  logic [IDX_W-1:0]       ch_idx;
  logic                   ch_ok;
  logic                   cp_ok;
  logic [COUNT_WIDTH-1:0] cnt_cur;
  logic [COUNT_WIDTH-1:0] cnt_dec;
  logic                   cnt_nz;

  // Decode of the incoming word.
  assign ch_idx   = IDX_W'(in_data.channel);
  assign ch_ok    = 32'(in_data.channel) < CHANNELS;
  assign cp_ok    = 32'(in_data.checkpoint) < CHECKPOINTS;
  assign acc_addr = AW'(32'(in_data.channel) * CHECKPOINTS + 32'(in_data.checkpoint));

  // Shared decrement unit, stepped over the channels during a tick.
  assign cnt_cur = countdown_r[idx_r];
  assign cnt_dec = cnt_cur - COUNT_WIDTH'(1);
  assign cnt_nz  = cnt_cur != '0;

  // Deadline table, one row of CHECKPOINTS entries per channel.
  cdw_ram #(
    .WIDTH (COUNT_WIDTH),
    .DEPTH (DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (acc_addr),
    .rdata (ram_rdata)
  );

  // Sequencer: next state, datapath updates and result capture.
  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    clr_nxt       = clr_r;
    ch_nxt        = ch_r;
    expired_nxt   = expired_r;
    armed_nxt     = armed_r;
    countdown_nxt = countdown_r;
    final_nxt     = final_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    ram_we        = 1'b0;
    ram_waddr     = acc_addr;
    ram_wdata     = COUNT_WIDTH'(in_data.deadline_value);

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_r;
        ram_wdata = '0;
        if (clr_r == AW'(DEPTH - 1)) begin
          state_nxt = ST_IDLE;
        end else begin
          clr_nxt = clr_r + AW'(1);
        end
      end

      ST_IDLE: begin
        if (in_valid) begin
          expired_nxt = '0;
          ch_nxt      = ch_idx;
          idx_nxt     = '0;
          state_nxt   = ST_FINISH;
          case (in_data.mode)
            MODE_TICK: begin
              state_nxt = ST_TICK;
            end
            MODE_REPORT: begin
              if (ch_ok) begin
                // Checkpoint zero always arms and loads the first deadline.
                if (in_data.checkpoint == '0) begin
                  armed_nxt[ch_idx] = 1'b1;
                  state_nxt         = ST_LOAD;
                end else if (in_data.checkpoint == final_r[ch_idx]) begin
                  armed_nxt[ch_idx] = 1'b0;
                end else if (cp_ok) begin
                  state_nxt = ST_LOAD;
                end
              end
            end
            MODE_WRITE_DL: begin
              ram_we = ch_ok && cp_ok;
            end
            default: begin
              if (ch_ok) begin
                final_nxt[ch_idx] = in_data.checkpoint;
              end
            end
          endcase
        end
      end

      ST_TICK: begin
        // An armed counter at zero holds and does not fire again.
        if (armed_r[idx_r] && cnt_nz) begin
          countdown_nxt[idx_r] = cnt_dec;
          if (cnt_dec == '0) begin
            expired_nxt[idx_r] = 1'b1;
          end
        end
        if (idx_r == IDX_W'(CHANNELS - 1)) begin
          state_nxt = ST_FINISH;
        end else begin
          idx_nxt = idx_r + IDX_W'(1);
        end
      end

      ST_LOAD: begin
        countdown_nxt[ch_r] = ram_rdata;
        state_nxt           = ST_FINISH;
      end

      ST_FINISH: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt             = 1'b1;
          out_data_nxt.expired_mask = MASK_W'(expired_r);
          out_data_nxt.armed_mask   = MASK_W'(armed_r);
          state_nxt                 = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State and control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      idx_r       <= '0;
      clr_r       <= '0;
      armed_r     <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < CHANNELS; i++) begin
        countdown_r[i] <= '0;
        final_r[i]     <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      clr_r       <= clr_nxt;
      armed_r     <= armed_nxt;
      out_valid_r <= out_valid_nxt;
      countdown_r <= countdown_nxt;
      final_r     <= final_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    ch_r       <= ch_nxt;
    expired_r  <= expired_nxt;
    out_data_r <= out_data_nxt;
  end

  assign in_ready  = state_r == ST_IDLE;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

### rtl/core/cdw_checker.sv
module cdw_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input cdw_pkg::out_word_t out_data
);

  import cdw_pkg::*;

  `include "checkpoint_deadline_watchdog_assert.svh"

  // A stalled result word stays put until it is taken.
  `CDW_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "result word changed while stalled")

  // Only an armed channel can expire, and a tick leaves the armed bits alone.
  `CDW_ASSERT_NOW(a_expired_armed, out_valid, (out_data.expired_mask & ~out_data.armed_mask) == '0, "expired channel is not armed")

  // The block works on one word at a time.
  `CDW_ASSERT_NEXT(a_one_at_a_time, in_valid && in_ready, !in_ready, "second word taken while busy")

  // A word taken never gets its result in the very next cycle.
  `CDW_ASSERT_NEXT(a_min_latency, in_valid && in_ready && !out_valid, !out_valid, "result appeared too early")

endmodule

bind checkpoint_deadline_watchdog cdw_checker u_cdw_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
